// File: hw/rtl/flv_tag_deframer_macros.svh
// ----------------------------------------------------------------------------
// FLV tag deframer assertion macros
// Concurrent assertion helpers that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef FLV_TAG_DEFRAMER_MACROS_SVH
`define FLV_TAG_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define FLVTD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("flv_tag_deframer assertion failed");
// Next-cycle implication, disabled during reset.
`define FLVTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flv_tag_deframer assertion failed");
`else
`define FLVTD_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define FLVTD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/flvtd_pkg.sv
// ----------------------------------------------------------------------------
// FLV tag deframer package
// Section codes, header byte offsets and the result record of one byte.
// ----------------------------------------------------------------------------
package flvtd_pkg;

   // Section that a stream byte belongs to.
   typedef enum logic [1:0] {
      SEC_FILE_HDR  = 2'd0,
      SEC_PREV_SIZE = 2'd1,
      SEC_TAG_HDR   = 2'd2,
      SEC_PAYLOAD   = 2'd3
   } section_type;

   // File header layout.
   localparam logic [31:0] FH_POS_VERSION  = 32'd3;
   localparam logic [31:0] FH_POS_FLAGS    = 32'd4;
   localparam logic [31:0] FH_POS_LEN_HEAD = 32'd5;
   localparam logic [31:0] FH_POS_LEN_TAIL = 32'd8;
   localparam logic [31:0] FH_MIN_LENGTH   = 32'd9;

   // Previous-tag-size field is four bytes.
   localparam logic [31:0] PS_POS_LAST = 32'd3;

   // Tag header layout, eleven bytes.
   localparam logic [31:0] TH_POS_KIND    = 32'd0;
   localparam logic [31:0] TH_POS_SIZE_2  = 32'd1;
   localparam logic [31:0] TH_POS_SIZE_1  = 32'd2;
   localparam logic [31:0] TH_POS_SIZE_0  = 32'd3;
   localparam logic [31:0] TH_POS_TS_2    = 32'd4;
   localparam logic [31:0] TH_POS_TS_1    = 32'd5;
   localparam logic [31:0] TH_POS_TS_0    = 32'd6;
   localparam logic [31:0] TH_POS_TS_EXT  = 32'd7;
   localparam logic [31:0] TH_POS_SID_2   = 32'd8;
   localparam logic [31:0] TH_POS_SID_1   = 32'd9;
   localparam logic [32:0] TH_BYTES       = 33'd11;

   // Result of one stream byte.
   typedef struct packed {
      section_type  section;
      logic [7:0]   byte_out;
      logic [7:0]   tag_kind;
      logic [23:0]  payload_size;
      logic [31:0]  full_timestamp;
      logic [23:0]  stream_number;
      logic [31:0]  previous_size;
      logic [7:0]   format_version;
      logic         audio_present;
      logic         video_present;
      logic         header_complete;
      logic         tag_end;
   } result_type;

endpackage

// File: hw/rtl/flvtd_in_reg.sv
// ----------------------------------------------------------------------------
// FLV tag deframer input register
// Holds one accepted stream byte until the parser takes it.
// ----------------------------------------------------------------------------
module flvtd_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_stream_byte,
   input  logic       take,
   output logic       held_valid,
   output logic [7:0] held_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   // The register is free when empty or when its byte leaves this cycle.
   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload captures on every accepted transaction.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_stream_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

// File: hw/rtl/flvtd_core.sv
// ----------------------------------------------------------------------------
// FLV tag deframer parse core
// Section state, position counter and field registers, updated once per byte.
// ----------------------------------------------------------------------------
module flvtd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             byte_in,
   output flvtd_pkg::result_type  result
);
   import flvtd_pkg::*;

   section_type phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] fhl_ff, fhl_in;
   logic [7:0]  kind_ff, kind_in;
   logic [23:0] psize_ff, psize_in;
   logic [31:0] ts_ff, ts_in;
   logic [23:0] sid_ff, sid_in;
   logic [31:0] prev_ff, prev_in;
   logic [7:0]  ver_ff, ver_in;
   logic [1:0]  flags_ff, flags_in;
   logic        hdr_done;
   logic        tag_end;
   logic [31:0] pos_inc;
   logic [32:0] pos_next_wide;

   assign pos_inc       = pos_ff + 32'd1;
   assign pos_next_wide = {1'b0, pos_ff} + 33'd1;

   // Next state and result fields for the byte at the input register.
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_inc;
      fhl_in   = fhl_ff;
      kind_in  = kind_ff;
      psize_in = psize_ff;
      ts_in    = ts_ff;
      sid_in   = sid_ff;
      prev_in  = prev_ff;
      ver_in   = ver_ff;
      flags_in = flags_ff;
      hdr_done = 1'b0;
      tag_end  = 1'b0;
      unique case (phase_ff)
         SEC_FILE_HDR: begin
            priority if (pos_ff == FH_POS_VERSION) begin
               ver_in = byte_in;
            end else if (pos_ff == FH_POS_FLAGS) begin
               flags_in = {byte_in[2], byte_in[0]};
            end else if (pos_ff == FH_POS_LEN_HEAD) begin
               fhl_in = {24'd0, byte_in};
            end else if (pos_ff > FH_POS_LEN_HEAD && pos_ff <= FH_POS_LEN_TAIL) begin
               fhl_in = {fhl_ff[23:0], byte_in};
            end else begin
               fhl_in = fhl_ff;
            end
            // A header length below the minimum is taken as the minimum.
            if (pos_ff == FH_POS_LEN_TAIL && fhl_in < FH_MIN_LENGTH) begin
               fhl_in = FH_MIN_LENGTH;
            end
            if (pos_ff >= FH_POS_LEN_TAIL && pos_next_wide >= {1'b0, fhl_in}) begin
               phase_in = SEC_PREV_SIZE;
               pos_in   = 32'd0;
            end
         end
         SEC_PREV_SIZE: begin
            prev_in = (pos_ff == 32'd0) ? {24'd0, byte_in} : {prev_ff[23:0], byte_in};
            if (pos_ff >= PS_POS_LAST) begin
               phase_in = SEC_TAG_HDR;
               pos_in   = 32'd0;
            end
         end
         SEC_TAG_HDR: begin
            unique case (pos_ff)
               TH_POS_KIND:   kind_in  = byte_in;
               TH_POS_SIZE_2: psize_in = {byte_in, 16'd0};
               TH_POS_SIZE_1: psize_in = psize_ff | {8'd0, byte_in, 8'd0};
               TH_POS_SIZE_0: psize_in = psize_ff | {16'd0, byte_in};
               TH_POS_TS_2:   ts_in    = {8'd0, byte_in, 16'd0};
               TH_POS_TS_1:   ts_in    = ts_ff | {16'd0, byte_in, 8'd0};
               TH_POS_TS_0:   ts_in    = ts_ff | {24'd0, byte_in};
               TH_POS_TS_EXT: ts_in    = {byte_in, ts_ff[23:0]};
               TH_POS_SID_2:  sid_in   = {byte_in, 16'd0};
               TH_POS_SID_1:  sid_in   = sid_ff | {8'd0, byte_in, 8'd0};
               default:       sid_in   = sid_ff | {16'd0, byte_in};
            endcase
            // Last header byte: an empty payload ends the tag right here.
            if (pos_next_wide >= TH_BYTES) begin
               hdr_done = 1'b1;
               pos_in   = 32'd0;
               if (psize_in == 24'd0) begin
                  tag_end  = 1'b1;
                  phase_in = SEC_PREV_SIZE;
               end else begin
                  phase_in = SEC_PAYLOAD;
               end
            end
         end
         SEC_PAYLOAD: begin
            if (pos_next_wide >= {9'd0, psize_ff}) begin
               tag_end  = 1'b1;
               phase_in = SEC_PREV_SIZE;
               pos_in   = 32'd0;
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // State advances only when the byte moves on to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SEC_FILE_HDR;
         pos_ff   <= 32'd0;
         fhl_ff   <= FH_MIN_LENGTH;
         kind_ff  <= 8'd0;
         psize_ff <= 24'd0;
         ts_ff    <= 32'd0;
         sid_ff   <= 24'd0;
         prev_ff  <= 32'd0;
         ver_ff   <= 8'd0;
         flags_ff <= 2'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         fhl_ff   <= fhl_in;
         kind_ff  <= kind_in;
         psize_ff <= psize_in;
         ts_ff    <= ts_in;
         sid_ff   <= sid_in;
         prev_ff  <= prev_in;
         ver_ff   <= ver_in;
         flags_ff <= flags_in;
      end
   end

   // Result fields show the values as they stand after this byte.
   always_comb begin
      result.section         = phase_ff;
      result.byte_out        = byte_in;
      result.tag_kind        = kind_in;
      result.payload_size    = psize_in;
      result.full_timestamp  = ts_in;
      result.stream_number   = sid_in;
      result.previous_size   = prev_in;
      result.format_version  = ver_in;
      result.audio_present   = flags_in[1];
      result.video_present   = flags_in[0];
      result.header_complete = hdr_done;
      result.tag_end         = tag_end;
   end

endmodule

// File: hw/rtl/flvtd_out_reg.sv
// ----------------------------------------------------------------------------
// FLV tag deframer result register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module flvtd_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  flvtd_pkg::result_type  load_data,
   output logic                   free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output flvtd_pkg::result_type  rsp_data
);
   import flvtd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // Room for a new result when empty or when the current one is taken.
   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: hw/rtl/flv_tag_deframer.sv
// Path: a byte accepted into the input register moves on into the result
// register, where its result transaction becomes valid, once the result
// register is free.
// Throughput: one byte per cycle while rsp_ready holds; the per-byte path is
// the 32-bit position increment and compare in the parse core.
// Reset: synchronous, active high; clears both registers and the parser state.
// ----------------------------------------------------------------------------
// FLV tag deframer
// Labels each byte of an FLV stream with its section and the current fields.
// ----------------------------------------------------------------------------
`include "flv_tag_deframer_macros.svh"

module flv_tag_deframer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_stream_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output flvtd_pkg::section_type    rsp_section,
   output logic [7:0]                rsp_byte_out,
   output logic [7:0]                rsp_tag_kind,
   output logic [23:0]               rsp_payload_size,
   output logic [31:0]               rsp_full_timestamp,
   output logic [23:0]               rsp_stream_number,
   output logic [31:0]               rsp_previous_size,
   output logic [7:0]                rsp_format_version,
   output logic                      rsp_audio_present,
   output logic                      rsp_video_present,
   output logic                      rsp_header_complete,
   output logic                      rsp_tag_end
);
   import flvtd_pkg::*;

   logic       held_valid;
   logic [7:0] held_byte;
   logic       out_free;
   logic       advance;
   result_type core_result;
   result_type rsp_data;
   logic       hdr_flagged;
   logic       end_flagged;
   logic       empty_hdr;
   logic       end_allowed;
   logic       stall_full;

   // A byte moves from the input register into the result register.
   assign advance = held_valid && out_free;

   flvtd_in_reg u_in_reg (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .take            (advance),
      .held_valid      (held_valid),
      .held_byte       (held_byte)
   );

   flvtd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .byte_in (held_byte),
      .result  (core_result)
   );

   flvtd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (core_result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Result transaction fields.
   assign rsp_section         = rsp_data.section;
   assign rsp_byte_out        = rsp_data.byte_out;
   assign rsp_tag_kind        = rsp_data.tag_kind;
   assign rsp_payload_size    = rsp_data.payload_size;
   assign rsp_full_timestamp  = rsp_data.full_timestamp;
   assign rsp_stream_number   = rsp_data.stream_number;
   assign rsp_previous_size   = rsp_data.previous_size;
   assign rsp_format_version  = rsp_data.format_version;
   assign rsp_audio_present   = rsp_data.audio_present;
   assign rsp_video_present   = rsp_data.video_present;
   assign rsp_header_complete = rsp_data.header_complete;
   assign rsp_tag_end         = rsp_data.tag_end;

   // Conditions watched by the checks below.
   assign hdr_flagged = rsp_valid && rsp_header_complete;
   assign end_flagged = rsp_valid && rsp_tag_end;
   assign empty_hdr   = rsp_header_complete && (rsp_payload_size == 24'd0);
   assign end_allowed = (rsp_section == SEC_PAYLOAD) || empty_hdr;
   assign stall_full  = held_valid && rsp_valid && !rsp_ready;

   // A completed header is only ever flagged on a tag header byte.
   `FLVTD_ASSERT_IMPLY(a_hdr_done_section, clock, reset, hdr_flagged, rsp_section == SEC_TAG_HDR)

   // A tag ends on a payload byte, or on the header's last byte of an empty tag.
   `FLVTD_ASSERT_IMPLY(a_tag_end_section, clock, reset, end_flagged, end_allowed)

   // An empty payload on the last header byte must end the tag.
   `FLVTD_ASSERT_IMPLY(a_empty_tag_end, clock, reset, rsp_valid && empty_hdr, rsp_tag_end)

   // With both registers full and the output stalled, no new byte comes in.
   `FLVTD_ASSERT_IMPLY(a_full_backpressure, clock, reset, stall_full, !req_ready)

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLV tag deframer testbench
// Builds one FLV byte stream at start-up: a file header of random length and
// then a run of tags. A clocked driver offers the bytes with random gaps. A
// clocked monitor takes the labeled bytes with random stalls, including one
// long hold-off that backs the block up. Every result transaction is checked
// field by field against a byte-level deframer kept in the testbench.
// ----------------------------------------------------------------------------
module testbench;
   import flvtd_pkg::*;

   // Tag type codes used to build the stream.
   localparam logic [7:0] TAG_AUDIO  = 8'd8;
   localparam logic [7:0] TAG_VIDEO  = 8'd9;
   localparam logic [7:0] TAG_SCRIPT = 8'd18;

   // Offset of the last byte of an eleven-byte tag header.
   localparam logic [31:0] TAG_HEADER_LAST = 32'd10;

   // Stream build targets and the long receiver hold-off.
   localparam int unsigned STREAM_TARGET    = 730;
   localparam int unsigned HOLD_AT_RESULT   = 120;
   localparam int unsigned HOLD_CYCLES      = 60;
   localparam int unsigned CALM_FIRST       = 300;
   localparam int unsigned CALM_LAST        = 450;
   localparam int unsigned MAX_REPORTS      = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   section_type rsp_section;
   logic [7:0]  rsp_byte_out;
   logic [7:0]  rsp_tag_kind;
   logic [23:0] rsp_payload_size;
   logic [31:0] rsp_full_timestamp;
   logic [23:0] rsp_stream_number;
   logic [31:0] rsp_previous_size;
   logic [7:0]  rsp_format_version;
   logic        rsp_audio_present;
   logic        rsp_video_present;
   logic        rsp_header_complete;
   logic        rsp_tag_end;

   // Bytes still to be offered and labels still to be received.
   logic [7:0]  stream_bytes[$];
   result_type  expected_labels[$];
   result_type  label_want;

   int unsigned offered_count = 0;
   int unsigned received_count = 0;
   int unsigned error_count = 0;
   int unsigned hold_left = 0;
   logic        hold_done = 1'b0;

   // Deframer state as it stands after the last accepted byte.
   section_type parse_sec = SEC_FILE_HDR;
   logic [31:0] parse_pos = 32'd0;
   logic [31:0] fh_length = FH_MIN_LENGTH;
   logic [7:0]  kind_now = 8'h00;
   logic [23:0] size_now = 24'h0;
   logic [31:0] ts_now = 32'h0;
   logic [23:0] sid_now = 24'h0;
   logic [31:0] prev_size_now = 32'h0;
   logic [7:0]  version_now = 8'h00;
   logic        audio_flag = 1'b0;
   logic        video_flag = 1'b0;

   flv_tag_deframer uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_stream_byte     (req_stream_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_section         (rsp_section),
      .rsp_byte_out        (rsp_byte_out),
      .rsp_tag_kind        (rsp_tag_kind),
      .rsp_payload_size    (rsp_payload_size),
      .rsp_full_timestamp  (rsp_full_timestamp),
      .rsp_stream_number   (rsp_stream_number),
      .rsp_previous_size   (rsp_previous_size),
      .rsp_format_version  (rsp_format_version),
      .rsp_audio_present   (rsp_audio_present),
      .rsp_video_present   (rsp_video_present),
      .rsp_header_complete (rsp_header_complete),
      .rsp_tag_end         (rsp_tag_end)
   );

   always #5 clock = ~clock;

   // Advance the deframer by one byte and return the label of that byte.
   function automatic result_type deframe_byte(input logic [7:0] b);
      result_type  r;
      section_type sec;
      logic        hdr_done;
      logic        last_byte;
      sec = parse_sec;
      hdr_done = 1'b0;
      last_byte = 1'b0;
      case (sec)
         SEC_FILE_HDR: begin
            if (parse_pos == FH_POS_VERSION) begin
               version_now = b;
            end else if (parse_pos == FH_POS_FLAGS) begin
               audio_flag = b[2];
               video_flag = b[0];
            end else if (parse_pos == FH_POS_LEN_HEAD) begin
               fh_length = {24'h0, b};
            end else if (parse_pos > FH_POS_LEN_HEAD && parse_pos <= FH_POS_LEN_TAIL) begin
               fh_length = {fh_length[23:0], b};
            end
            // A header length below the minimum is taken as the minimum.
            if (parse_pos == FH_POS_LEN_TAIL && fh_length < FH_MIN_LENGTH)
               fh_length = FH_MIN_LENGTH;
            if (parse_pos >= FH_POS_LEN_TAIL &&
                {1'b0, parse_pos} + 33'd1 >= {1'b0, fh_length}) begin
               parse_sec = SEC_PREV_SIZE;
               parse_pos = 32'd0;
            end else begin
               parse_pos = parse_pos + 32'd1;
            end
         end
         SEC_PREV_SIZE: begin
            prev_size_now = (parse_pos == 32'd0) ? {24'h0, b} : {prev_size_now[23:0], b};
            if (parse_pos >= PS_POS_LAST) begin
               parse_sec = SEC_TAG_HDR;
               parse_pos = 32'd0;
            end else begin
               parse_pos = parse_pos + 32'd1;
            end
         end
         SEC_TAG_HDR: begin
            // The first byte of a field clears its lower bytes.
            case (parse_pos)
               TH_POS_KIND:   kind_now = b;
               TH_POS_SIZE_2: size_now = {b, 16'h0};
               TH_POS_SIZE_1: size_now[15:8] = b;
               TH_POS_SIZE_0: size_now[7:0] = b;
               TH_POS_TS_2:   ts_now = {8'h00, b, 16'h0};
               TH_POS_TS_1:   ts_now[15:8] = b;
               TH_POS_TS_0:   ts_now[7:0] = b;
               TH_POS_TS_EXT: ts_now[31:24] = b;
               TH_POS_SID_2:  sid_now = {b, 16'h0};
               TH_POS_SID_1:  sid_now[15:8] = b;
               default:       sid_now[7:0] = b;
            endcase
            if (parse_pos >= TAG_HEADER_LAST) begin
               hdr_done = 1'b1;
               parse_pos = 32'd0;
               // An empty payload ends the tag on the header's last byte.
               if (size_now == 24'h0) begin
                  last_byte = 1'b1;
                  parse_sec = SEC_PREV_SIZE;
               end else begin
                  parse_sec = SEC_PAYLOAD;
               end
            end else begin
               parse_pos = parse_pos + 32'd1;
            end
         end
         default: begin
            if ({1'b0, parse_pos} + 33'd1 >= {9'h0, size_now}) begin
               last_byte = 1'b1;
               parse_sec = SEC_PREV_SIZE;
               parse_pos = 32'd0;
            end else begin
               parse_pos = parse_pos + 32'd1;
            end
         end
      endcase
      r.section = sec;
      r.byte_out = b;
      r.tag_kind = kind_now;
      r.payload_size = size_now;
      r.full_timestamp = ts_now;
      r.stream_number = sid_now;
      r.previous_size = prev_size_now;
      r.format_version = version_now;
      r.audio_present = audio_flag;
      r.video_present = video_flag;
      r.header_complete = hdr_done;
      r.tag_end = last_byte;
      return r;
   endfunction

   // Random idle decision, switched off over a calm window of transactions.
   function automatic bit take_break(input int unsigned count);
      return ($urandom_range(0, 99) < 11) && !(count >= CALM_FIRST && count < CALM_LAST);
   endfunction

   // Append a big-endian value of the given byte count to the stream.
   task automatic push_bytes(input logic [31:0] value, input int count);
      for (int i = count - 1; i >= 0; i--)
         stream_bytes.insert(stream_bytes.size(), value[8*i +: 8]);
   endtask

   // Append a previous-tag size, a tag header and body_len random payload bytes.
   task automatic push_tag(input logic [31:0] prev, input logic [7:0] kind,
                           input logic [23:0] size, input logic [31:0] stamp,
                           input logic [23:0] sid, input int body_len);
      push_bytes(prev, 4);
      push_bytes({24'h0, kind}, 1);
      push_bytes({8'h0, size}, 3);
      push_bytes({8'h0, stamp[23:0]}, 3);
      push_bytes({24'h0, stamp[31:24]}, 1);
      push_bytes({8'h0, sid}, 3);
      for (int i = 0; i < body_len; i++)
         push_bytes($urandom, 1);
   endtask

   // Build the whole stream: file header, one directed tag, random tags, then a truncated tag.
   task automatic build_stream();
      logic [31:0] header_len;
      logic [31:0] prev_v;
      logic [23:0] size_v;
      logic [23:0] last_size;
      logic [23:0] sid_v;
      logic [7:0]  kind_v;
      int unsigned pick;
      // The header length may be short (clamped), exact, or long with skipped bytes.
      header_len = $urandom_range(0, 24);
      push_bytes(32'h0046_4C56, 3);
      push_bytes($urandom, 1);
      push_bytes($urandom, 1);
      push_bytes(header_len, 4);
      for (int i = 9; i < int'(header_len); i++)
         push_bytes($urandom, 1);
      // Empty payload, unknown type, and timestamp and stream number at their maximum.
      push_tag(32'h0, 8'hFF, 24'h0, 32'hFFFF_FFFF, 24'hFF_FFFF, 0);
      last_size = 24'h0;
      while (stream_bytes.size() < STREAM_TARGET) begin
         pick = $urandom_range(0, 9);
         case ($urandom_range(0, 3))
            0:       kind_v = TAG_AUDIO;
            1:       kind_v = TAG_VIDEO;
            2:       kind_v = TAG_SCRIPT;
            default: kind_v = 8'($urandom);
         endcase
         if (pick == 0)
            size_v = 24'h0;
         else if (pick <= 7)
            size_v = 24'($urandom_range(1, 16));
         else
            size_v = 24'($urandom_range(17, 64));
         // Mostly consistent back pointers, sometimes garbage.
         prev_v = ($urandom_range(0, 4) == 0) ? $urandom : 32'd11 + last_size;
         sid_v = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'h0;
         push_tag(prev_v, kind_v, size_v, $urandom, sid_v, int'(size_v));
         last_size = size_v;
      end
      // The stream stops inside a tag with the largest payload size.
      push_tag(32'd11 + last_size, TAG_VIDEO, 24'hFF_FFFF, $urandom, 24'($urandom), 12);
   endtask

   // Compare one field of a result transaction.
   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         error_count++;
         if (error_count <= MAX_REPORTS)
            $display("Mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
                     name, received_count, want_v, got_v);
      end
   endtask

   // Driver: offer stream bytes and predict the label of each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_stream_byte <= 8'h00;
      end else begin
         if (req_valid && req_ready)
            expected_labels.insert(expected_labels.size(), deframe_byte(req_stream_byte));
         if (!req_valid || req_ready) begin
            if (stream_bytes.size() > 0 && !take_break(offered_count)) begin
               req_valid <= 1'b1;
               req_stream_byte <= stream_bytes.pop_front();
               offered_count <= offered_count + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver ready: random stalls plus one long hold-off to fill the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && received_count >= HOLD_AT_RESULT) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= !take_break(received_count);
      end
   end

   // Monitor: check each result transaction against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         received_count <= received_count + 1;
         if (expected_labels.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("Unexpected result %0d: byte 0x%0h with no prediction waiting",
                        received_count, rsp_byte_out);
         end else begin
            label_want = expected_labels.pop_front();
            check_field("section", 32'(label_want.section), 32'(rsp_section));
            check_field("byte_out", 32'(label_want.byte_out), 32'(rsp_byte_out));
            check_field("tag_kind", 32'(label_want.tag_kind), 32'(rsp_tag_kind));
            check_field("payload_size", 32'(label_want.payload_size),
                        32'(rsp_payload_size));
            check_field("full_timestamp", label_want.full_timestamp,
                        rsp_full_timestamp);
            check_field("stream_number", 32'(label_want.stream_number),
                        32'(rsp_stream_number));
            check_field("previous_size", label_want.previous_size, rsp_previous_size);
            check_field("format_version", 32'(label_want.format_version),
                        32'(rsp_format_version));
            check_field("audio_present", 32'(label_want.audio_present),
                        32'(rsp_audio_present));
            check_field("video_present", 32'(label_want.video_present),
                        32'(rsp_video_present));
            check_field("header_complete", 32'(label_want.header_complete),
                        32'(rsp_header_complete));
            check_field("tag_end", 32'(label_want.tag_end), 32'(rsp_tag_end));
         end
      end
   end

   // Run control: build the stream, reset, drain, then report.
   initial begin
      build_stream();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (stream_bytes.size() != 0 || req_valid || expected_labels.size() != 0)
         @(negedge clock);
      // Allow for the two-stage pipeline to show any stray result.
      repeat (10) @(negedge clock);
      if (error_count == 0 && expected_labels.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Timeout guard.
   initial begin
      #1_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
